[rtl/utf8_stream_decoder_defines.svh]
// Assertion macros used by the port-level checker of the UTF-8 stream decoder.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held low.
`define USD_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("usd assertion failed");

// Next-cycle implication, disabled while reset is held low.
`define USD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("usd assertion failed");

`endif

[rtl/usd_pkg.sv]
// Types, constants and small decode functions of the UTF-8 stream decoder.
// Depends on nothing; used by usd_decode and utf8_stream_decoder.
package usd_pkg;

  localparam logic [30:0] USD_MAX_CP_RESET = 31'h10FFFF;
  localparam logic [2:0]  USD_MAX_CONT     = 3'd5;

  typedef struct packed {
    logic        has_result;
    logic [30:0] code_point;
    logic [3:0]  seq_length;
    logic        status;
  } usd_result_t;

  // Count of consecutive ones below the top bit of a lead byte, from 0 to 7.
  function automatic logic [2:0] lead_count(input logic [7:0] b);
    logic [2:0] n;
    logic       run;
    n   = '0;
    run = 1'b1;
    for (int i = 6; i >= 0; i--) begin
      if (run && b[i]) begin
        n = n + 3'd1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  // Bit position of the lead payload for a given continuation count.
  function automatic logic [4:0] lead_shift(input logic [2:0] n);
    logic [4:0] s;
    case (n)
      3'd1:    s = 5'd5;
      3'd2:    s = 5'd10;
      3'd3:    s = 5'd15;
      3'd4:    s = 5'd20;
      3'd5:    s = 5'd25;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Smallest value that is not overlong for a given continuation count.
  function automatic logic [31:0] min_value(input logic [2:0] n);
    logic [31:0] m;
    case (n)
      3'd1:    m = 32'h0000_0080;
      3'd2:    m = 32'h0000_0800;
      3'd3:    m = 32'h0001_0000;
      3'd4:    m = 32'h0020_0000;
      3'd5:    m = 32'h0400_0000;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

[rtl/utf8_stream_decoder.sv]
// Top level of the UTF-8 stream decoder: input register, decode core, result register.
// Depends on usd_pkg and usd_decode.
//
// Usage: bytes of a UTF-8 stream arrive as beats on the in_ channel (valid/ready),
// one byte per beat. Each completed sequence, or each malformed piece of input,
// leaves as one beat on the out_ channel carrying the code point, the number of
// bytes consumed and a status bit (1 for malformed, overlong or above the limit).
// Lead and inner continuation bytes produce no output beat.
// An accepted byte is held in the input register and decoded from there into the
// result register, which takes the decoded result once it is free.
// Throughput: one byte per cycle sustained while the output is not stalled; the
// sequence state is updated by a single shift-and-compare pass, so decoding never slows it.
// Stall: when out_ready is low while a result waits, the input register holds its
// byte and in_ready drops once that register is occupied; no beat is lost.
// Reset (rst_n low, synchronous): both registers empty, the decoder idle, and the
// code point limit back to 0x10FFFF. cfg_max_code_point is written whenever
// cfg_we is high and should only change while the block is idle.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [30:0] cfg_max_code_point,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] out_code_point,
  output logic [3:0]  out_seq_length,
  output logic        out_status
);
  import usd_pkg::*;

  // Input register: one byte waiting to be decoded.
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  logic [30:0] out_cp_r;
  logic [3:0]  out_len_r;
  logic        out_status_r;

  logic        out_free;
  logic        step;
  usd_result_t res;

  // The decoder advances whenever the result register can take a new value,
  // whether or not the byte in hand produces one.
  assign out_free = !out_valid_r || out_ready;
  assign step     = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  usd_decode u_decode (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_max_code_point (cfg_max_code_point),
    .step               (step),
    .data_byte          (s1_byte_r),
    .result             (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = step && res.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_data_byte;
    end
    if (step && res.has_result) begin
      out_cp_r     <= res.code_point;
      out_len_r    <= res.seq_length;
      out_status_r <= res.status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_cp_r;
  assign out_seq_length = out_len_r;
  assign out_status     = out_status_r;

endmodule

[rtl/usd_decode.sv]
// Sequence state, limit register and per-byte decode logic of the UTF-8 decoder.
// Depends on usd_pkg.
module usd_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_max_code_point,
  input  logic               step,
  input  logic [7:0]         data_byte,
  output usd_pkg::usd_result_t result
);
  import usd_pkg::*;

  logic [2:0]  rem_r, rem_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [23:0] acc_r;
  logic [29:0] acc_nxt;
  logic [6:0]  lp_r, lp_nxt;
  logic [30:0] max_r;

  logic [2:0]  n_lead;
  logic [6:0]  lead_shifted;
  logic [2:0]  n_fin;
  logic [31:0] value;
  logic        bad;

  always_comb begin
    n_lead       = lead_count(data_byte);
    lead_shifted = data_byte[6:0] << n_lead;
    n_fin        = cnt_r + 3'd1;
    acc_nxt      = {acc_r, data_byte[5:0]};
    value        = {2'b00, acc_nxt} | ({25'd0, lp_r} << lead_shift(n_fin));
    bad          = (value > {1'b0, max_r}) || (value < min_value(n_fin));

    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    lp_nxt  = lp_r;
    result  = '0;

    if (rem_r == 3'd0) begin
      if (!data_byte[7]) begin
        result.has_result = 1'b1;
        result.code_point = {23'd0, data_byte};
        result.seq_length = 4'd1;
      end else if (n_lead == 3'd0) begin
        // Continuation byte with no open sequence.
        result.has_result = 1'b1;
        result.seq_length = 4'd1;
        result.status     = 1'b1;
      end else begin
        rem_nxt = n_lead;
        cnt_nxt = '0;
        lp_nxt  = lead_shifted;
      end
    end else if (data_byte[7:6] != 2'b10) begin
      // Sequence broken by a byte that is not a continuation; it is consumed.
      result.has_result = 1'b1;
      result.seq_length = {1'b0, cnt_r} + 4'd2;
      result.status     = 1'b1;
      rem_nxt = '0;
      cnt_nxt = '0;
      lp_nxt  = '0;
    end else begin
      cnt_nxt = n_fin;
      rem_nxt = rem_r - 3'd1;
      if (rem_r == 3'd1) begin
        result.has_result = 1'b1;
        result.seq_length = {1'b0, n_fin} + 4'd1;
        if ((n_fin > USD_MAX_CONT) || bad) begin
          result.status = 1'b1;
        end else begin
          result.code_point = value[30:0];
        end
        cnt_nxt = '0;
        lp_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      cnt_r <= '0;
      acc_r <= '0;
      lp_r  <= '0;
      max_r <= USD_MAX_CP_RESET;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_max_code_point;
      end
      if (step) begin
        rem_r <= rem_nxt;
        cnt_r <= cnt_nxt;
        lp_r  <= lp_nxt;
        if (rem_r == 3'd0) begin
          acc_r <= '0;
        end else begin
          acc_r <= acc_nxt[23:0];
        end
      end
    end
  end

endmodule

[rtl/usd_checker.sv]
// Port-level checker for the UTF-8 stream decoder, bound to the top level.
// Depends on utf8_stream_decoder_defines.svh and utf8_stream_decoder.
`include "utf8_stream_decoder_defines.svh"

module usd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [30:0] out_code_point,
  input logic [3:0]  out_seq_length,
  input logic        out_status
);

  logic [35:0] out_payload;

  assign out_payload = {out_code_point, out_seq_length, out_status};

  // A stalled result keeps its payload.
  `USD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_payload))

  // An error result always carries a zero code point.
  `USD_ASSERT_IMPLY(a_err_zero, clk, rst_n, out_valid && out_status, out_code_point == 31'd0)

  // Every result consumed between one and eight bytes.
  `USD_ASSERT_IMPLY(a_len_range, clk, rst_n, out_valid, out_seq_length != 4'd0 && out_seq_length <= 4'd8)

  // A good single-byte result is plain ASCII.
  `USD_ASSERT_IMPLY(a_ascii, clk, rst_n, out_valid && !out_status && out_seq_length == 4'd1, out_code_point < 31'd128)

endmodule

bind utf8_stream_decoder usd_checker u_usd_checker (.*);
